>>> rtl/core/lsfx_pkg.sv
// Shared types and constants for the LSB-first serial exchange master.
// No dependencies; used by the engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lsfx_pkg;

  // Bits shifted per byte
  localparam int unsigned BITS_PER_BYTE = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP         = 2'd1;

  // Register reset values
  localparam logic [15:0] HALF_PERIOD_RST = 16'd10;
  localparam logic [15:0] GAP_RST         = 16'd20;

  // One input item: one time tick
  typedef struct packed {
    logic       data_pin;
    logic       byte_offered;
    logic [7:0] tx_byte;
    logic       tx_last;
  } tick_t;

  // One result item: pin levels after the tick plus receive status
  typedef struct packed {
    logic       select_n;
    logic       clock_pin;
    logic       command_pin;
    logic       ready_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/lsb_first_serial_exchange_master.sv
// LSB-first serial exchange master, top level: tick queue, engine, result queue.
// Depends on lsfx_pkg, lsfx_queue and lsfx_engine.
//
// Usage: each item pushed on the in_ channel is one time tick carrying the
// sampled data pin and an optional command byte (byte_offered, tx_byte,
// tx_last). For every tick exactly one result item comes out on the out_
// channel, in order: pin levels after the tick (select_n, clock_pin,
// command_pin), ready_res when the offered byte was taken, and rx_valid with
// rx_byte/rx_last on the tick a received byte completes.
// Throughput: one tick per clock cycle; the engine advances one tick per cycle
// whenever the tick queue holds an item and the result queue has room.
// A pushed tick is stored in the tick queue, then in the result queue once the
// engine steps it, and then shows on out_ (empty low). Both queues hold two items,
// so with the receiver stalled up to four ticks are held before in_full rises;
// nothing is lost. Configuration (cfg_index 0 half period, 1 gap) is always ready;
// write it only while no tick is in flight, as the block does not enforce it.
// Reset: synchronous, active low; queues empty, engine idle with all pins high,
// half period 10 ticks and gap 20 ticks.
`timescale 1ns / 1ps
`default_nettype none

module lsb_first_serial_exchange_master #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lsfx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  // tick input
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic                           in_data_pin,
  input  wire logic                           in_byte_offered,
  input  wire logic [7:0]                     in_tx_byte,
  input  wire logic                           in_tx_last,
  // result output
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic                                out_select_n,
  output logic                                out_clock_pin,
  output logic                                out_command_pin,
  output logic                                out_ready_res,
  output logic                                out_rx_valid,
  output logic [7:0]                          out_rx_byte,
  output logic                                out_rx_last
);

  localparam int unsigned TickW = $bits(lsfx_pkg::tick_t);
  localparam int unsigned ResW  = $bits(lsfx_pkg::res_t);

  lsfx_pkg::tick_t tick_in, tick_q;
  lsfx_pkg::res_t  res, res_q;
  logic [TickW-1:0] tick_q_bits;
  logic [ResW-1:0]  res_q_bits;
  logic             tick_empty, tick_take, res_full;

  assign cfg_ready = 1'b1;

  // Pack the incoming tick
  assign tick_in.data_pin     = in_data_pin;
  assign tick_in.byte_offered = in_byte_offered;
  assign tick_in.tx_byte      = in_tx_byte;
  assign tick_in.tx_last      = in_tx_last;

  // Front queue
  lsfx_queue #(.Width(TickW), .Depth(QueueDepth)) u_tick_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (tick_in),
    .full      (in_full),
    .pop       (tick_take),
    .pop_data  (tick_q_bits),
    .empty     (tick_empty)
  );

  assign tick_q = tick_q_bits;

  // Sequencer
  lsfx_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_avail (!tick_empty),
    .tick       (tick_q),
    .tick_take  (tick_take),
    .res_room   (!res_full),
    .res        (res)
  );

  // Back queue
  lsfx_queue #(.Width(ResW), .Depth(QueueDepth)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick_take),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_q_bits),
    .empty     (out_empty)
  );

  // Unpack the oldest result
  assign res_q           = res_q_bits;
  assign out_select_n    = res_q.select_n;
  assign out_clock_pin   = res_q.clock_pin;
  assign out_command_pin = res_q.command_pin;
  assign out_ready_res   = res_q.ready_res;
  assign out_rx_valid    = res_q.rx_valid;
  assign out_rx_byte     = res_q.rx_byte;
  assign out_rx_last     = res_q.rx_last;

endmodule

`default_nettype wire

>>> rtl/core/lsfx_queue.sv
// Small first-in first-out queue used on both sides of the serial engine.
// Depends on nothing; width and depth come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module lsfx_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [Width-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      pop_data,
  output logic                  empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] entries_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CntFull);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lsfx_engine.sv
// Serial engine: steps the bit/gap sequencer by one tick per queued item.
// Depends on lsfx_pkg for the tick and result types and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module lsfx_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [lsfx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                       cfg_data,
  // tick side (front queue)
  input  wire logic                              tick_avail,
  input  wire lsfx_pkg::tick_t                   tick,
  output logic                                   tick_take,
  // result side (back queue)
  input  wire logic                              res_room,
  output lsfx_pkg::res_t                         res
);

  // Sequencer phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOW  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_GAP  = 3'd3;
  localparam logic [2:0] PH_WAIT = 3'd4;

  // Pin vector bit positions
  localparam int unsigned PIN_SEL = 2;
  localparam int unsigned PIN_CLK = 1;
  localparam int unsigned PIN_CMD = 0;

  localparam logic [2:0] LAST_BIT = 3'(lsfx_pkg::BITS_PER_BYTE - 1);

  logic [15:0] half_r, gap_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  pins_r, pins_nxt;

  logic        step;
  logic [15:0] half_eff;
  logic [16:0] tick_inc;
  logic [2:0]  bit_inc;
  logic        half_done;

  assign step      = tick_avail && res_room;
  assign tick_take = step;
  assign half_eff  = (half_r == '0) ? 16'd1 : half_r;
  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign bit_inc   = bit_r + 3'd1;
  assign half_done = (tick_inc >= {1'b0, half_eff});

  // Next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    last_nxt  = last_r;
    pins_nxt  = pins_r;
    res       = '0;

    unique case (phase_r)
      PH_LOW: begin
        if (half_done) begin
          pins_nxt[PIN_CLK] = 1'b1;
          rx_nxt[bit_r]     = rx_r[bit_r] | tick.data_pin;
          tick_nxt          = '0;
          phase_nxt         = PH_HIGH;
        end else begin
          tick_nxt = tick_inc[15:0];
        end
      end
      PH_HIGH: begin
        if (half_done) begin
          tick_nxt = '0;
          if (bit_r == LAST_BIT) begin
            // byte complete: hand it out, clock and command back high
            res.rx_valid      = 1'b1;
            res.rx_byte       = rx_r;
            res.rx_last       = last_r;
            pins_nxt[PIN_CLK] = 1'b1;
            pins_nxt[PIN_CMD] = 1'b1;
            bit_nxt           = '0;
            if (gap_r == '0) begin
              pins_nxt  = last_r ? 3'b111 : 3'b011;
              phase_nxt = last_r ? PH_IDLE : PH_WAIT;
            end else begin
              phase_nxt = PH_GAP;
            end
          end else begin
            bit_nxt           = bit_inc;
            pins_nxt[PIN_CMD] = tx_r[bit_inc];
            pins_nxt[PIN_CLK] = 1'b0;
            phase_nxt         = PH_LOW;
          end
        end else begin
          tick_nxt = tick_inc[15:0];
        end
      end
      PH_GAP: begin
        tick_nxt = tick_inc[15:0];
        if (tick_inc >= {1'b0, gap_r}) begin
          tick_nxt  = '0;
          pins_nxt  = last_r ? 3'b111 : 3'b011;
          phase_nxt = last_r ? PH_IDLE : PH_WAIT;
        end
      end
      default: begin
        // idle or waiting between bytes
        if (tick.byte_offered) begin
          res.ready_res     = 1'b1;
          tx_nxt            = tick.tx_byte;
          rx_nxt            = '0;
          last_nxt          = tick.tx_last;
          bit_nxt           = '0;
          tick_nxt          = '0;
          pins_nxt[PIN_SEL] = 1'b0;
          pins_nxt[PIN_CMD] = tick.tx_byte[0];
          pins_nxt[PIN_CLK] = 1'b0;
          phase_nxt         = PH_LOW;
        end else if (phase_r != PH_WAIT) begin
          phase_nxt = PH_IDLE;
          pins_nxt  = 3'b111;
        end
      end
    endcase

    res.select_n    = pins_nxt[PIN_SEL];
    res.clock_pin   = pins_nxt[PIN_CLK];
    res.command_pin = pins_nxt[PIN_CMD];
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= lsfx_pkg::HALF_PERIOD_RST;
      gap_r   <= lsfx_pkg::GAP_RST;
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      tick_r  <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      last_r  <= 1'b0;
      pins_r  <= 3'b111;
    end else begin
      if (cfg_we && cfg_index == lsfx_pkg::REG_HALF_PERIOD) begin
        half_r <= cfg_data;
      end
      if (cfg_we && cfg_index == lsfx_pkg::REG_GAP) begin
        gap_r <= cfg_data;
      end
      if (step) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        tick_r  <= tick_nxt;
        tx_r    <= tx_nxt;
        rx_r    <= rx_nxt;
        last_r  <= last_nxt;
        pins_r  <= pins_nxt;
      end
    end
  end

  // Select is low whenever a byte or its gap is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LOW || phase_r == PH_HIGH || phase_r == PH_GAP) |-> !pins_r[PIN_SEL])
    else $error("select high during a byte");

  // Clock is low exactly in the low half of a bit
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LOW) == !pins_r[PIN_CLK])
    else $error("clock level does not match phase");

  // A completed byte always leaves clock and command high
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.rx_valid) |=> (pins_r[PIN_CLK] && pins_r[PIN_CMD]))
    else $error("pins not released after byte");

  // Bit counter only moves inside a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_WAIT || phase_r == PH_GAP) |-> (bit_r == '0))
    else $error("bit counter nonzero outside a byte");

endmodule

`default_nettype wire
